@@ src/cvr_pkg.sv @@
// shared constants, register and command codes, and the arctangent table for the vector rotator
package cvr_pkg;

  localparam int CoordBitsDef  = 12;
  localparam int VectorBitsDef = 16;
  localparam int CordicStepsDef = 16;

  localparam int PtrW     = 12;
  localparam int CompW    = 16;
  localparam int SensW    = 20;
  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 20;

  localparam logic [PtrW-1:0]  CentreReset = 12'd512;
  localparam logic [SensW-1:0] SensReset   = 20'd2097;

  localparam logic [CfgIdxW-1:0] CfgCentre = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgSens   = 2'd1;

  localparam logic CmdMove = 1'b0;
  localparam logic CmdLoad = 1'b1;

  localparam int Guard     = 16;
  localparam int AngW      = 24;
  localparam int GainW     = 31;
  localparam int TwoPiQ    = 6588397;
  localparam int HalfTurnQ = 3294198;
  localparam int QuarterQ  = 1647099;
  localparam logic [GainW-1:0] GainQ30 = 31'd652032874;

  function automatic logic signed [AngW-1:0] atan_entry(input logic [4:0] idx);
    logic signed [AngW-1:0] res;
    case (idx)
      5'd0: res = 24'sd823550;
      5'd1: res = 24'sd486170;
      5'd2: res = 24'sd256879;
      5'd3: res = 24'sd130396;
      5'd4: res = 24'sd65451;
      5'd5: res = 24'sd32757;
      5'd6: res = 24'sd16383;
      default: begin
        if (idx > 5'd20) res = '0;
        else res = 24'sd1 <<< (5'd20 - idx);
      end
    endcase
    return res;
  endfunction

endpackage

@@ src/cvr_if.sv @@
// valid/ready channel interfaces for items, results and register writes
interface cvr_in_if;
  logic                                valid;
  logic                                ready;
  logic                                command;
  logic        [cvr_pkg::PtrW-1:0]     pointer_x;
  logic signed [cvr_pkg::CompW-1:0]    load_dir_x;
  logic signed [cvr_pkg::CompW-1:0]    load_dir_y;
  logic signed [cvr_pkg::CompW-1:0]    load_plane_x;
  logic signed [cvr_pkg::CompW-1:0]    load_plane_y;

  modport source (output valid, command, pointer_x, load_dir_x, load_dir_y, load_plane_x,
                  load_plane_y, input ready);
  modport sink   (input valid, command, pointer_x, load_dir_x, load_dir_y, load_plane_x,
                  load_plane_y, output ready);
endinterface

interface cvr_out_if;
  logic                             valid;
  logic                             ready;
  logic signed [cvr_pkg::CompW-1:0] out_dir_x;
  logic signed [cvr_pkg::CompW-1:0] out_dir_y;
  logic signed [cvr_pkg::CompW-1:0] out_plane_x;
  logic signed [cvr_pkg::CompW-1:0] out_plane_y;
  logic                             rotated;

  modport source (output valid, out_dir_x, out_dir_y, out_plane_x, out_plane_y, rotated,
                  input ready);
  modport sink   (input valid, out_dir_x, out_dir_y, out_plane_x, out_plane_y, rotated,
                  output ready);
endinterface

interface cvr_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [cvr_pkg::CfgIdxW-1:0]     index;
  logic [cvr_pkg::CfgDataW-1:0]    data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

@@ src/camera_vector_rotator.sv @@
// camera vector rotator: holds direction and plane vectors, rotates them by pointer moves
//
// Channels: in_i takes one command per transfer (load all four components, or a pointer
// move); out_o returns one result per command with the four components after the command
// and a rotated flag; cfg_i writes centre_position (index 0) and sensitivity (index 1) and
// is always ready.
// Sequence: a load goes straight to the output step; a move passes through S_MUL, S_WRAP,
// S_MOD and S_CHK, and goes to the output step from there if the reduced angle is zero;
// a move that rotates then runs S_GX, S_GY, S_PRE, S_ITER and S_FIN once per vector
// before S_OUT.
// in_i.ready rises with out_o.valid, so a new command is not taken until the last result is offered.
// One shared multiplier forms the angle and the gain products; the angle is reduced
// modulo one turn one shifted compare-subtract per cycle; one shared adder set runs
// CORDIC_STEPS iterations per vector, direction first, then plane.
// in_i.ready is high only while the sequencer is idle, so one item is in flight at a time.
// The result register lets the next item be taken while a result waits; a finished item
// holds in its last step until out_o is free.
// Reset clears all four components to zero and restores the register reset values.
module camera_vector_rotator #(
  parameter int COORD_BITS   = cvr_pkg::CoordBitsDef,
  parameter int VECTOR_BITS  = cvr_pkg::VectorBitsDef,
  parameter int CORDIC_STEPS = cvr_pkg::CordicStepsDef
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  cvr_in_if.sink    in_i,
  cvr_out_if.source out_o,
  cvr_cfg_if.sink   cfg_i
);

  localparam int PosW  = (COORD_BITS < cvr_pkg::PtrW) ? COORD_BITS : cvr_pkg::PtrW;
  localparam int DW    = PosW + 1;
  localparam int AW    = DW + cvr_pkg::SensW;
  localparam int RedK  = AW - 23;
  localparam int VW    = AW + 1;
  localparam int KW    = (RedK > 0) ? $clog2(RedK + 1) : 1;
  localparam int MaW   = (DW > VECTOR_BITS) ? DW : VECTOR_BITS;
  localparam int PW    = MaW + cvr_pkg::GainW + 1;
  localparam int XW    = VECTOR_BITS + cvr_pkg::Guard + 2;
  localparam int IW    = $clog2(CORDIC_STEPS);
  localparam int GShift = 30 - cvr_pkg::Guard;
  localparam int AngW  = cvr_pkg::AngW;

  localparam logic signed [XW-1:0] VecMax = XW'((64'sd1 <<< (VECTOR_BITS - 1)) - 64'sd1);
  localparam logic signed [XW-1:0] VecMin = -VecMax - XW'(1);
  localparam logic signed [XW-1:0] RoundHalf = XW'(64'sd1 <<< (cvr_pkg::Guard - 1));
  localparam logic signed [AngW-1:0] QuarterA = AngW'(cvr_pkg::QuarterQ);
  localparam logic [VW-1:0] TwoPiV = VW'(cvr_pkg::TwoPiQ);

  typedef enum logic [10:0] {
    S_IDLE = 11'b00000000001,
    S_MUL  = 11'b00000000010,
    S_WRAP = 11'b00000000100,
    S_MOD  = 11'b00000001000,
    S_CHK  = 11'b00000010000,
    S_GX   = 11'b00000100000,
    S_GY   = 11'b00001000000,
    S_PRE  = 11'b00010000000,
    S_ITER = 11'b00100000000,
    S_FIN  = 11'b01000000000,
    S_OUT  = 11'b10000000000
  } state_e;

  function automatic logic signed [VECTOR_BITS-1:0] sat_vec(input logic signed [XW-1:0] v);
    logic signed [XW-1:0] r;
    if (v > VecMax) r = VecMax;
    else if (v < VecMin) r = VecMin;
    else r = v;
    return r[VECTOR_BITS-1:0];
  endfunction

  function automatic logic signed [cvr_pkg::CompW-1:0] to_port(
      input logic signed [VECTOR_BITS-1:0] v);
    logic signed [XW-1:0] t;
    t = XW'(v);
    return t[cvr_pkg::CompW-1:0];
  endfunction

  state_e state_q, state_d;

  logic [cvr_pkg::PtrW-1:0]  centre_q;
  logic [cvr_pkg::SensW-1:0] sens_q;

  logic signed [VECTOR_BITS-1:0] dir_x_q, dir_y_q, pl_x_q, pl_y_q;
  logic signed [DW-1:0]   d_q;
  logic signed [AW-1:0]   a_q;
  logic        [VW-1:0]   v_q;
  logic        [KW-1:0]   k_q;
  logic signed [AngW-1:0] w_q;
  logic signed [XW-1:0]   x_q, y_q;
  logic        [IW-1:0]   i_q;
  logic                   vsel_q;
  logic                   rot_q;

  logic                          out_valid_q;
  logic signed [cvr_pkg::CompW-1:0] o_dx_q, o_dy_q, o_px_q, o_py_q;
  logic                          o_rot_q;

  logic in_xfer, out_free;
  logic signed [MaW-1:0] mul_a;
  logic [cvr_pkg::GainW-1:0] mul_b;
  logic signed [PW-1:0] prod;
  logic [VW:0] wrap_sum;
  logic [VW-1:0] mod_sub;
  logic signed [XW-1:0] dx, dy, rx, ry;
  logic signed [AngW-1:0] atan_v;
  logic signed [VECTOR_BITS-1:0] cur_x, cur_y;
  logic [DW-1:0] pos_ext, cen_ext;

  assign in_i.ready  = (state_q == S_IDLE);
  assign cfg_i.ready = 1'b1;
  assign in_xfer     = in_i.valid && in_i.ready;
  assign out_free    = !out_valid_q || out_o.ready;

  assign out_o.valid       = out_valid_q;
  assign out_o.out_dir_x   = o_dx_q;
  assign out_o.out_dir_y   = o_dy_q;
  assign out_o.out_plane_x = o_px_q;
  assign out_o.out_plane_y = o_py_q;
  assign out_o.rotated     = o_rot_q;

  assign pos_ext = DW'(in_i.pointer_x[PosW-1:0]);
  assign cen_ext = DW'(centre_q[PosW-1:0]);

  assign cur_x = vsel_q ? pl_x_q : dir_x_q;
  assign cur_y = vsel_q ? pl_y_q : dir_y_q;

  // shared multiplier: angle product, then gain products
  always_comb begin
    mul_a = MaW'(d_q);
    mul_b = cvr_pkg::GainW'(sens_q);
    if (state_q == S_GX) begin
      mul_a = MaW'(cur_x);
      mul_b = cvr_pkg::GainQ30;
    end else if (state_q == S_GY) begin
      mul_a = MaW'(cur_y);
      mul_b = cvr_pkg::GainQ30;
    end
  end
  assign prod = mul_a * $signed({1'b0, mul_b});

  assign wrap_sum = {{2{a_q[AW-1]}}, a_q} + (VW + 1)'(cvr_pkg::HalfTurnQ)
                  + ((VW + 1)'(cvr_pkg::TwoPiQ) << RedK);
  assign mod_sub  = TwoPiV << k_q;

  assign dx     = y_q >>> i_q;
  assign dy     = x_q >>> i_q;
  assign atan_v = cvr_pkg::atan_entry(5'(i_q));
  assign rx     = (x_q + RoundHalf) >>> cvr_pkg::Guard;
  assign ry     = (y_q + RoundHalf) >>> cvr_pkg::Guard;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_xfer) state_d = (in_i.command == cvr_pkg::CmdLoad) ? S_OUT : S_MUL;
      end
      S_MUL:  state_d = S_WRAP;
      S_WRAP: state_d = S_MOD;
      S_MOD:  if (k_q == '0) state_d = S_CHK;
      S_CHK:  state_d = (v_q == VW'(cvr_pkg::HalfTurnQ)) ? S_OUT : S_GX;
      S_GX:   state_d = S_GY;
      S_GY:   state_d = S_PRE;
      S_PRE:  state_d = S_ITER;
      S_ITER: if (i_q == IW'(CORDIC_STEPS - 1)) state_d = S_FIN;
      S_FIN:  state_d = vsel_q ? S_OUT : S_GX;
      S_OUT:  if (out_free) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      centre_q    <= cvr_pkg::CentreReset;
      sens_q      <= cvr_pkg::SensReset;
      dir_x_q     <= '0;
      dir_y_q     <= '0;
      pl_x_q      <= '0;
      pl_y_q      <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_i.valid) begin
        unique case (cfg_i.index)
          cvr_pkg::CfgCentre: centre_q <= cfg_i.data[cvr_pkg::PtrW-1:0];
          cvr_pkg::CfgSens:   sens_q   <= cfg_i.data[cvr_pkg::SensW-1:0];
          default: ;
        endcase
      end
      if (in_xfer && in_i.command == cvr_pkg::CmdLoad) begin
        dir_x_q <= sat_vec(XW'(in_i.load_dir_x));
        dir_y_q <= sat_vec(XW'(in_i.load_dir_y));
        pl_x_q  <= sat_vec(XW'(in_i.load_plane_x));
        pl_y_q  <= sat_vec(XW'(in_i.load_plane_y));
      end
      if (state_q == S_FIN) begin
        if (vsel_q) begin
          pl_x_q <= sat_vec(rx);
          pl_y_q <= sat_vec(ry);
        end else begin
          dir_x_q <= sat_vec(rx);
          dir_y_q <= sat_vec(ry);
        end
      end
      if (state_q == S_OUT && out_free) out_valid_q <= 1'b1;
      else if (out_o.ready) out_valid_q <= 1'b0;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      d_q    <= $signed(pos_ext - cen_ext);
      rot_q  <= 1'b0;
      vsel_q <= 1'b0;
    end
    unique case (state_q)
      S_MUL:  a_q <= prod[AW-1:0];
      S_WRAP: begin
        v_q <= wrap_sum[VW-1:0];
        k_q <= KW'(RedK);
      end
      S_MOD: begin
        if (v_q >= mod_sub) v_q <= v_q - mod_sub;
        k_q <= k_q - KW'(1);
      end
      S_CHK:  w_q <= $signed(AngW'(v_q) - AngW'(cvr_pkg::HalfTurnQ));
      S_GX:   x_q <= prod[GShift +: XW];
      S_GY:   y_q <= prod[GShift +: XW];
      S_PRE: begin
        i_q <= '0;
        if (w_q > QuarterA) begin
          x_q <= -y_q;
          y_q <= x_q;
          w_q <= w_q - QuarterA;
        end else if (w_q < -QuarterA) begin
          x_q <= y_q;
          y_q <= -x_q;
          w_q <= w_q + QuarterA;
        end
      end
      S_ITER: begin
        i_q <= i_q + IW'(1);
        if (!w_q[AngW-1]) begin
          x_q <= x_q - dx;
          y_q <= y_q + dy;
          w_q <= w_q - atan_v;
        end else begin
          x_q <= x_q + dx;
          y_q <= y_q - dy;
          w_q <= w_q + atan_v;
        end
      end
      S_FIN: begin
        vsel_q <= 1'b1;
        if (vsel_q) rot_q <= 1'b1;
        if (!vsel_q) w_q <= $signed(AngW'(v_q) - AngW'(cvr_pkg::HalfTurnQ));
      end
      default: ;
    endcase
    if (state_q == S_OUT && out_free) begin
      o_dx_q  <= to_port(dir_x_q);
      o_dy_q  <= to_port(dir_y_q);
      o_px_q  <= to_port(pl_x_q);
      o_py_q  <= to_port(pl_y_q);
      o_rot_q <= rot_q;
    end
  end

endmodule

@@ src/cvr_checker.sv @@
// port-level checks for the camera vector rotator, bound to the top level
module cvr_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [15:0] out_dir_x_i,
  input logic [15:0] out_dir_y_i,
  input logic [15:0] out_plane_x_i,
  input logic [15:0] out_plane_y_i,
  input logic        out_rotated_i,
  input logic        cfg_valid_i,
  input logic        cfg_ready_i
);

  // result stays offered until taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result dropped before transfer");

  // stalled result holds its payload
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(out_dir_x_i) && $stable(out_dir_y_i)
      && $stable(out_plane_x_i) && $stable(out_plane_y_i) && $stable(out_rotated_i))
    else $error("stalled result changed");

  // one item in flight: input closes right after a transfer
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("input taken while busy");

  // no result can appear in the cycle right after an input transfer
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i && !out_valid_i |=> !out_valid_i)
    else $error("result appeared too early");

  // register writes never stall
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i |-> cfg_ready_i)
    else $error("register write stalled");

endmodule

bind camera_vector_rotator cvr_checker u_cvr_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_i.valid),
  .in_ready_i    (in_i.ready),
  .out_valid_i   (out_o.valid),
  .out_ready_i   (out_o.ready),
  .out_dir_x_i   (out_o.out_dir_x),
  .out_dir_y_i   (out_o.out_dir_y),
  .out_plane_x_i (out_o.out_plane_x),
  .out_plane_y_i (out_o.out_plane_y),
  .out_rotated_i (out_o.rotated),
  .cfg_valid_i   (cfg_i.valid),
  .cfg_ready_i   (cfg_i.ready)
);
